>>> design/mam_pkg.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit package
// Shared widths, opcodes, reset modulus and the multiplier request and response types.
// ----------------------------------------------------------------------------
package mam_pkg;

  localparam int OPC_W     = 3;
  localparam int RES_W     = 31;
  localparam int OPB_W     = 32;
  localparam int MUL_STEPS = OPB_W;
  localparam int STEP_W    = $clog2(MUL_STEPS);

  localparam logic [RES_W-1:0] MOD_RESET = 31'd998244353;

  typedef enum logic [OPC_W-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_POW = 3'd3,
    OP_INV = 3'd4,
    OP_DIV = 3'd5
  } opcode_t;

  typedef struct packed {
    logic             start;
    logic [OPB_W-1:0] x;
    logic [RES_W-1:0] y;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [RES_W-1:0] prod;
  } mul_rsp_t;

endpackage

>>> design/mam_if.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit channels
// Valid/ready channels for the command request and the residue response.
// ----------------------------------------------------------------------------
interface mam_cmd_if;
  logic                      valid;
  logic                      ready;
  logic [mam_pkg::OPC_W-1:0] opcode;
  logic [mam_pkg::RES_W-1:0] operand_a;
  logic [mam_pkg::OPB_W-1:0] operand_b;

  modport source (output valid, opcode, operand_a, operand_b, input ready);
  modport sink   (input valid, opcode, operand_a, operand_b, output ready);
endinterface

interface mam_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [mam_pkg::RES_W-1:0] residue;

  modport source (output valid, residue, input ready);
  modport sink   (input valid, residue, output ready);
endinterface

>>> design/mam_mulmod.sv
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Scans x one bit per cycle, most significant first: acc = 2*acc + bit*y mod m.
// ----------------------------------------------------------------------------
module mam_mulmod (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [mam_pkg::RES_W-1:0] modulus,
  input  mam_pkg::mul_req_t         req,
  output mam_pkg::mul_rsp_t         rsp
);
  import mam_pkg::*;

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] cnt;
  logic [OPB_W-1:0]  xs;
  logic [RES_W-1:0]  y;
  logic [RES_W-1:0]  acc;
  logic [RES_W-1:0]  acc_next;
  logic [RES_W:0]    dbl;
  logic [RES_W:0]    dbl_red;
  logic [RES_W:0]    sum;
  logic [RES_W:0]    mod_ext;

  always_comb begin
    mod_ext = {1'b0, modulus};
    dbl     = {acc, 1'b0};
    dbl_red = (dbl >= mod_ext) ? dbl - mod_ext : dbl;
    sum     = dbl_red + (xs[OPB_W-1] ? {1'b0, y} : '0);
    acc_next = (sum >= mod_ext) ? RES_W'(sum - mod_ext) : sum[RES_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        xs   <= req.x;
        y    <= req.y;
        acc  <= '0;
      end else if (busy) begin
        acc <= acc_next;
        xs  <= {xs[OPB_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.prod = acc;

endmodule

>>> design/modular_arithmetic_unit_top.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit
// Add, subtract, multiply, power, inverse and divide modulo a configured modulus.
// ----------------------------------------------------------------------------
//  channel  dir  payload                          handshake
//  cmd      in   opcode, operand_a, operand_b     valid / ready
//  rsp      out  residue                          valid / ready
//  cfg      in   modulus (cfg_wdata)              cfg_we, no wait
//
//  One request at a time; every product runs in the one bit-serial multiplier.
//  Both operands are reduced first; multiply then adds one product, power squares
//  and multiplies over up to WIDTH exponent bits, inverse likewise over the bits
//  of modulus-2, divide one more. A modulus below 2 or unused opcode returns 0.
//  Reset is synchronous; the next request is taken while a residue waits on rsp.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit_top #(
  parameter int WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [mam_pkg::RES_W-1:0] cfg_wdata,
  mam_cmd_if.sink                   cmd,
  mam_rsp_if.source                 rsp
);
  import mam_pkg::*;

  localparam int CNT_W = $clog2(WIDTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_WAIT,
    S_DISPATCH,
    S_POW,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    K_RED_A,
    K_RED_B,
    K_POW_ACC,
    K_POW_SQR,
    K_MUL_AB
  } step_t;

  state_t           state;
  step_t            step;
  logic [RES_W-1:0] modulus;
  logic [OPC_W-1:0] op;
  logic [OPB_W-1:0] b_raw;
  logic [RES_W-1:0] a_red;
  logic [RES_W-1:0] b_red;
  logic [RES_W-1:0] acc;
  logic [RES_W-1:0] base;
  logic [OPB_W-1:0] expo;
  logic [CNT_W-1:0] icnt;
  logic [RES_W-1:0] residue;
  logic             out_valid;
  mul_req_t         mul_req;
  mul_rsp_t         mul_rsp;

  logic [RES_W:0]   sum_ab;
  logic [RES_W-1:0] add_res;
  logic [RES_W-1:0] sub_res;
  logic             pow_end;
  logic             out_free;
  logic             mul_issue;

  mam_mulmod u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .modulus (modulus),
    .req     (mul_req),
    .rsp     (mul_rsp)
  );

  always_comb begin
    sum_ab  = {1'b0, a_red} + {1'b0, b_red};
    add_res = (sum_ab >= {1'b0, modulus}) ? RES_W'(sum_ab - {1'b0, modulus})
                                          : sum_ab[RES_W-1:0];
    sub_res = (a_red >= b_red) ? a_red - b_red
                               : RES_W'({1'b0, a_red} + {1'b0, modulus} - {1'b0, b_red});
    pow_end  = (icnt == CNT_W'(WIDTH)) || (expo == '0);
    out_free = !out_valid || rsp.ready;
    unique case (state)
      S_IDLE:     mul_issue = cmd.valid && modulus >= RES_W'(2) && cmd.opcode <= OP_DIV;
      S_MUL_WAIT: mul_issue = mul_rsp.done && (step == K_RED_A || step == K_POW_ACC);
      S_DISPATCH: mul_issue = (op == OP_MUL);
      S_POW:      mul_issue = !pow_end || (op == OP_DIV);
      default:    mul_issue = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_RESET;
    end else if (cfg_we) begin
      modulus <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      step          <= K_RED_A;
      out_valid     <= 1'b0;
      mul_req.start <= 1'b0;
    end else begin
      mul_req.start <= mul_issue;
      out_valid     <= (state == S_DONE && out_free) || (out_valid && !rsp.ready);
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            op    <= cmd.opcode;
            b_raw <= cmd.operand_b;
            if (modulus < RES_W'(2) || cmd.opcode > OP_DIV) begin
              acc   <= '0;
              state <= S_DONE;
            end else begin
              mul_req.x <= {1'b0, cmd.operand_a};
              mul_req.y <= RES_W'(1);
              step      <= K_RED_A;
              state     <= S_MUL_WAIT;
            end
          end
        end
        S_MUL_WAIT: begin
          if (mul_rsp.done) begin
            unique case (step)
              K_RED_A: begin
                a_red     <= mul_rsp.prod;
                mul_req.x <= b_raw;
                mul_req.y <= RES_W'(1);
                step      <= K_RED_B;
              end
              K_RED_B: begin
                b_red <= mul_rsp.prod;
                state <= S_DISPATCH;
              end
              K_POW_ACC: begin
                acc       <= mul_rsp.prod;
                mul_req.x <= {1'b0, base};
                mul_req.y <= base;
                step      <= K_POW_SQR;
              end
              K_POW_SQR: begin
                base  <= mul_rsp.prod;
                expo  <= expo >> 1;
                icnt  <= icnt + 1'b1;
                state <= S_POW;
              end
              K_MUL_AB: begin
                acc   <= mul_rsp.prod;
                state <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_DISPATCH: begin
          icnt <= '0;
          case (op)
            OP_ADD: begin
              acc   <= add_res;
              state <= S_DONE;
            end
            OP_SUB: begin
              acc   <= sub_res;
              state <= S_DONE;
            end
            OP_MUL: begin
              mul_req.x <= {1'b0, a_red};
              mul_req.y <= b_red;
              step      <= K_MUL_AB;
              state     <= S_MUL_WAIT;
            end
            OP_POW: begin
              acc   <= RES_W'(1);
              base  <= a_red;
              expo  <= b_raw;
              state <= S_POW;
            end
            OP_INV: begin
              base  <= a_red;
              expo  <= {1'b0, modulus - RES_W'(2)};
              if (a_red == '0) begin
                acc   <= '0;
                state <= S_DONE;
              end else begin
                acc   <= RES_W'(1);
                state <= S_POW;
              end
            end
            OP_DIV: begin
              base  <= b_red;
              expo  <= {1'b0, modulus - RES_W'(2)};
              if (b_red == '0) begin
                acc   <= '0;
                state <= S_DONE;
              end else begin
                acc   <= RES_W'(1);
                state <= S_POW;
              end
            end
            default: begin
              acc   <= '0;
              state <= S_DONE;
            end
          endcase
        end
        S_POW: begin
          if (pow_end) begin
            if (op == OP_DIV) begin
              mul_req.x <= {1'b0, a_red};
              mul_req.y <= acc;
              step      <= K_MUL_AB;
              state     <= S_MUL_WAIT;
            end else begin
              state <= S_DONE;
            end
          end else if (expo[0]) begin
            mul_req.x <= {1'b0, acc};
            mul_req.y <= base;
            step      <= K_POW_ACC;
            state     <= S_MUL_WAIT;
          end else begin
            mul_req.x <= {1'b0, base};
            mul_req.y <= base;
            step      <= K_POW_SQR;
            state     <= S_MUL_WAIT;
          end
        end
        S_DONE: begin
          if (out_free) begin
            residue <= acc;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign cmd.ready   = (state == S_IDLE);
  assign rsp.valid   = out_valid;
  assign rsp.residue = residue;

endmodule

>>> design/mam_checker.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit checker
// Port-level checks on request acceptance, response timing and reset.
// ----------------------------------------------------------------------------
module mam_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      cmd_valid,
  input logic                      cmd_ready,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic [mam_pkg::RES_W-1:0] rsp_residue
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_residue))
    else $error("response dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("request taken while previous one still in progress");

  a_rsp_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(!cmd_ready))
    else $error("response appeared without a request in progress");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !rsp_valid && cmd_ready)
    else $error("reset did not clear the response or free the request side");

endmodule

bind modular_arithmetic_unit_top mam_checker u_mam_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_residue (rsp.residue)
);

>>> dv/tb_modular_arithmetic_unit_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modular arithmetic unit testbench
// Sends add, subtract, multiply, power, inverse, divide and unused-opcode
// requests under several moduli, predicts each residue in the bench, and
// checks every response in order while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_modular_arithmetic_unit_top;
  import mam_pkg::*;

  localparam logic [OPC_W-1:0] OPC_UNUSED6 = 3'd6;
  localparam logic [OPC_W-1:0] OPC_UNUSED7 = 3'd7;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int DRAIN_TAIL     = 2500;
  localparam int RANDOM_PER_MOD = 27;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [RES_W-1:0] cfg_wdata;

  mam_cmd_if cmd_if ();
  mam_rsp_if rsp_if ();

  logic [RES_W-1:0] cur_modulus = MOD_RESET;
  logic [RES_W-1:0] residue_q[$];
  bit               quiet_mode = 1'b0;
  int               error_count = 0;
  int               stall_left = 0;
  int               idle_cycles = 0;

  modular_arithmetic_unit_top #(.WIDTH(32)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd_if),
    .rsp       (rsp_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [63:0] mulmod(input logic [63:0] x, input logic [63:0] y,
                                         input logic [63:0] m);
    return (x * y) % m;
  endfunction

  function automatic logic [63:0] powmod(input logic [63:0] base, input logic [31:0] e,
                                         input logic [63:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [31:0] rem;
    acc = 64'd1 % m;
    sq  = base;
    rem = e;
    for (int i = 0; i < 32 && rem != 0; i++) begin
      if (rem[0])
        acc = mulmod(acc, sq, m);
      sq  = mulmod(sq, sq, m);
      rem = rem >> 1;
    end
    return acc;
  endfunction

  function automatic logic [63:0] invmod(input logic [63:0] x, input logic [63:0] m);
    if (x == 0)
      return 64'd0;
    return powmod(x, 32'(m - 64'd2), m);
  endfunction

  function automatic logic [RES_W-1:0] predict_residue(input logic [OPC_W-1:0] op,
                                                       input logic [RES_W-1:0] a_raw,
                                                       input logic [OPB_W-1:0] b_raw);
    logic [63:0] m;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] r;
    m = 64'(cur_modulus);
    if (m < 2)
      return '0;
    a = 64'(a_raw) % m;
    b = 64'(b_raw) % m;
    case (op)
      OP_ADD: begin
        r = a + b;
        if (r >= m)
          r = r - m;
      end
      OP_SUB: r = (a >= b) ? a - b : a + m - b;
      OP_MUL: r = mulmod(a, b, m);
      OP_POW: r = powmod(a, b_raw, m);
      OP_INV: r = invmod(a, m);
      OP_DIV: r = mulmod(a, invmod(b, m), m);
      default: r = 64'd0;
    endcase
    return r[RES_W-1:0];
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet_mode)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [OPC_W-1:0] pick_opcode();
    case ($urandom_range(0, 19))
      0, 1, 2:    return OP_ADD;
      3, 4, 5:    return OP_SUB;
      6, 7, 8:    return OP_MUL;
      9, 10, 11:  return OP_POW;
      12, 13, 14: return OP_INV;
      15, 16, 17: return OP_DIV;
      18:         return OPC_UNUSED6;
      default:    return OPC_UNUSED7;
    endcase
  endfunction

  function automatic logic [RES_W-1:0] pick_operand_a();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return cur_modulus;
      3:       return cur_modulus - 1'b1;
      4:       return RES_W'($urandom_range(0, 15));
      default: return RES_W'($urandom());
    endcase
  endfunction

  function automatic logic [OPB_W-1:0] pick_operand_b();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return OPB_W'(cur_modulus);
      3:       return OPB_W'(cur_modulus) - 1'b1;
      4:       return OPB_W'($urandom_range(0, 15));
      5:       return OPB_W'(cur_modulus) << 1;
      default: return OPB_W'($urandom());
    endcase
  endfunction

  task automatic send_request(input logic [OPC_W-1:0] op, input logic [RES_W-1:0] a,
                              input logic [OPB_W-1:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.opcode    <= op;
    cmd_if.operand_a <= a;
    cmd_if.operand_b <= b;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
  endtask

  // drop valid and hold until every residue is back
  task automatic finish_phase();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (residue_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_modulus(input logic [RES_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    cur_modulus = value;
    @(posedge clk);
  endtask

  task automatic test_reset_modulus();
    send_request(OP_ADD, '1, '1);
    send_request(OP_ADD, MOD_RESET - 1'b1, 32'd1);
    send_request(OP_SUB, '0, '1);
    send_request(OP_MUL, MOD_RESET - 1'b1, 32'(MOD_RESET) - 1'b1);
    send_request(OP_MUL, '1, '1);
    send_request(OP_POW, '0, '0);
    send_request(OP_POW, '1, '1);
    send_request(OP_POW, 31'd3, 32'h8000_0000);
    send_request(OP_INV, '0, '1);
    send_request(OP_INV, MOD_RESET, '0);
    send_request(OP_INV, '1, '0);
    send_request(OP_DIV, '1, '0);
    send_request(OP_DIV, 31'd1, '1);
    send_request(OPC_UNUSED6, '1, '1);
    send_request(OPC_UNUSED7, '1, '1);
    finish_phase();
  endtask

  task automatic test_small_moduli();
    set_modulus('0);
    send_request(OP_POW, '0, '0);
    send_request(OP_ADD, '1, '1);
    finish_phase();
    set_modulus(31'd1);
    send_request(OP_POW, 31'd5, '0);
    send_request(OP_INV, 31'd1, '0);
    finish_phase();
    set_modulus(31'd2);
    send_request(OP_INV, 31'd1, '0);
    send_request(OP_INV, 31'd2, '0);
    send_request(OP_DIV, 31'd1, 32'd3);
    finish_phase();
  endtask

  task automatic test_composite_modulus();
    set_modulus(31'd15);
    send_request(OP_INV, 31'd2, '0);
    send_request(OP_DIV, 31'd7, 32'd4);
    finish_phase();
  endtask

  task automatic test_random_moduli();
    logic [RES_W-1:0] moduli[10];
    moduli = '{31'h7FFF_FFFF, 31'd2, 31'd3, 31'd65537, 31'd1000000007, 31'd1000000,
               31'd0, 31'd998244353, 31'd0, 31'd0};
    moduli[6] = RES_W'($urandom_range(2, 32'h7FFF_FFFF));
    moduli[9] = RES_W'($urandom());
    for (int s = 0; s < 10; s++) begin
      set_modulus(moduli[s]);
      quiet_mode = (s % 3 == 1);
      repeat (RANDOM_PER_MOD) send_request(pick_opcode(), pick_operand_a(), pick_operand_b());
      finish_phase();
    end
    quiet_mode = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!quiet_mode && $urandom_range(0, 3) == 0) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= pick_gap();
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_residue
    logic [RES_W-1:0] want;
    if (!rst) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (residue_q.size() == 0) begin
          $error("residue %0d arrived with no request outstanding", rsp_if.residue);
          error_count++;
        end else begin
          want = residue_q.pop_front();
          if (rsp_if.residue !== want) begin
            $error("residue mismatch: expected %0d, actual %0d", want, rsp_if.residue);
            error_count++;
          end
        end
      end
      if (cmd_if.valid && cmd_if.ready)
        residue_q.push_back(predict_residue(cmd_if.opcode, cmd_if.operand_a,
                                            cmd_if.operand_b));
    end
  end

  always @(posedge clk) begin
    if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    cmd_if.valid     <= 1'b0;
    cmd_if.opcode    <= '0;
    cmd_if.operand_a <= '0;
    cmd_if.operand_b <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_modulus();
    test_small_moduli();
    test_composite_modulus();
    test_random_moduli();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (error_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
